@@ hdl/msort_pkg.sv @@
package msort_pkg;

  // Number of cells, which is also the largest set that can be sorted.
  localparam int DEPTH = 64;
  // The load counter holds 0 .. DEPTH-1.
  localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VAL_W = 32;

  // Input item
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    last_res;
  } out_item_t;

  // Broadcast control shared by every cell
  typedef struct packed {
    logic                    ins;
    logic                    shift;
    logic signed [VAL_W-1:0] new_value;
  } cell_ctrl_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    vld;
    logic                    gt;
  } cell_link_t;

  // Edge of the chain: no data, never displaced
  localparam cell_link_t LINK_NONE = '{value: '0, vld: 1'b0, gt: 1'b0};

endpackage

@@ hdl/msort_cell.sv @@
module msort_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msort_pkg::cell_ctrl_t   ctrl,
  input  msort_pkg::cell_link_t   left_i,
  input  msort_pkg::cell_link_t   right_i,
  output msort_pkg::cell_link_t   link_o
);

  logic signed [msort_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                               vld_r, vld_nxt;
  logic                               gt;

  // An empty cell counts as greater than any new value
  assign gt = !vld_r || ($signed(value_r) > $signed(ctrl.new_value));

  // Insert: displaced cells take the left neighbor; the first displaced one takes the new value.
  // Drain: every cell takes the right neighbor.
  always_comb begin
    value_nxt = value_r;
    vld_nxt   = vld_r;
    priority if (ctrl.shift) begin
      value_nxt = right_i.value;
      vld_nxt   = right_i.vld;
    end else if (ctrl.ins && gt) begin
      if (left_i.gt) begin
        value_nxt = left_i.value;
        vld_nxt   = left_i.vld;
      end else begin
        value_nxt = ctrl.new_value;
        vld_nxt   = 1'b1;
      end
    end else begin
      // not displaced: hold
      value_nxt = value_r;
      vld_nxt   = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // data holds no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link_o = '{value: value_r, vld: vld_r, gt: gt};

endmodule

@@ hdl/merge_sorter_top.sv @@
// Sorter for sets of signed 32-bit values, up to DEPTH (64) values per set.
// Input channel (in_valid / in_stall / in_item): one value per item; an item
// with last set closes the set, and the DEPTH-th item closes it regardless.
// Result channel (out_valid / out_stall / out_item): the set in ascending
// order, one value per item, last_res set on the final one.
// Timing: each input item is placed, as it is taken, into a
// chain of compare cells that always holds the loaded values in order. The
// first result is offered in the cycle after the closing item; results then
// leave at one per cycle while out_stall is low, the chain shifting toward
// cell 0, which serves as the output register.
// in_stall is high while a set drains; the next set loads once the final
// result has been taken.
// A stalled result holds: the chain does not shift while out_stall is high.
// Reset empties all cells and returns to loading with no values held.
module merge_sorter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  msort_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output msort_pkg::out_item_t  out_item
);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t                       state_r, state_nxt;
  logic [msort_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         in_acc, out_acc, end_set;
  msort_pkg::cell_ctrl_t        ctrl;
  msort_pkg::cell_link_t        link_w [msort_pkg::DEPTH];

  // Handshakes
  assign in_stall  = (state_r == ST_DRAIN);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign end_set   = in_item.last ||
                     (cnt_r == msort_pkg::CNT_W'(msort_pkg::DEPTH - 1));

  // Chain control
  assign ctrl = '{ins: in_acc, shift: out_acc, new_value: in_item.value};

  // Row of cells, cell 0 at the output end
  for (genvar i = 0; i < msort_pkg::DEPTH; i++) begin : g_cell
    msort_pkg::cell_link_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = msort_pkg::LINK_NONE;
    end else begin : g_left
      assign left_w = link_w[i-1];
    end
    if (i == msort_pkg::DEPTH - 1) begin : g_lastc
      assign right_w = msort_pkg::LINK_NONE;
    end else begin : g_right
      assign right_w = link_w[i+1];
    end
    msort_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .link_o  (link_w[i])
    );
  end

  // Result comes straight from cell 0; the run ends when cell 1 is empty
  assign out_item = '{value_res: link_w[0].value, last_res: !link_w[1].vld};

  // Load counter and phase
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (end_set) begin
            state_nxt = ST_DRAIN;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_item.last_res) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // A closing item starts the drain in the next cycle
  a_close_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.last) |=> out_valid)
    else $error("set closed but no result offered");

  // The two front cells are in order while draining
  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && link_w[1].vld) |->
      ($signed(link_w[0].value) <= $signed(link_w[1].value)))
    else $error("front cells out of order");

  // Cell 0 holds a value whenever a result is offered
  a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> link_w[0].vld)
    else $error("result offered from an empty cell");

  // After the final result the chain is empty and loading resumes
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_item.last_res) |=> (!out_valid && !link_w[0].vld && cnt_r == '0))
    else $error("chain not empty after final result");
`endif

endmodule

@@ bench/merge_sorter_top_test.sv @@
module merge_sorter_top_test;

  // Holds the set being loaded and the sorted results still owed by the block
  class sorted_set_board;
    logic signed [msort_pkg::VAL_W-1:0] loading_q[$];
    msort_pkg::out_item_t               sorted_q[$];
    int                                 errors;

    function new();
      errors = 0;
    endfunction

    // Record an accepted item; a closed set is sorted into expected results
    function void note_value(msort_pkg::in_item_t it);
      logic signed [msort_pkg::VAL_W-1:0] key;
      msort_pkg::out_item_t               res;
      int                                 j;
      int                                 n;
      loading_q.push_back(it.value);
      if (it.last || loading_q.size() == msort_pkg::DEPTH) begin
        n = loading_q.size();
        // stable insertion sort: equal values keep their load order
        for (int i = 1; i < n; i++) begin
          key = loading_q[i];
          j = i;
          while (j > 0 && loading_q[j-1] > key) begin
            loading_q[j] = loading_q[j-1];
            j--;
          end
          loading_q[j] = key;
        end
        for (int k = 0; k < n; k++) begin
          res.value_res = loading_q[k];
          res.last_res  = (k == n - 1);
          sorted_q.push_back(res);
        end
        loading_q.delete();
      end
    endfunction

    // Compare one accepted result with the oldest expected one
    function void check_value(msort_pkg::out_item_t got);
      msort_pkg::out_item_t want;
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d last %0b", got.value_res, got.last_res);
        return;
      end
      want = sorted_q.pop_front();
      if (got.value_res !== want.value_res || got.last_res !== want.last_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                   want.value_res, want.last_res, got.value_res, got.last_res);
      end
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  msort_pkg::in_item_t  in_item;
  logic                 out_valid;
  logic                 out_stall;
  msort_pkg::out_item_t out_item;

  int in_idle_pct;
  int out_idle_pct;
  int sent;
  bit hold_go;
  bit hold_out;

  sorted_set_board board;

  merge_sorter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one item, idling first at random, and wait until it is taken
  task automatic send_value(logic signed [msort_pkg::VAL_W-1:0] v, bit is_last);
    msort_pkg::in_item_t it;
    it.value = v;
    it.last  = is_last;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    board.note_value(it);
    sent++;
    @(negedge clk);
  endtask

  // Mix of full-range words, small values that tie often, and the extremes
  function automatic logic signed [msort_pkg::VAL_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      return $urandom;
    else if (pick <= 7)
      return $signed($urandom_range(0, 8)) - 4;
    else if (pick == 8)
      return 32'sh7FFF_FFFF;
    else
      return 32'sh8000_0000;
  endfunction

  // Random sets until the item count reaches the target; some fill the store
  task automatic send_random_sets(int target);
    int n;
    bit close_flag;
    while (sent < target) begin
      n = ($urandom_range(0, 9) == 0) ? msort_pkg::DEPTH : $urandom_range(1, 12);
      // a full set closes on its own, so its final last bit is random
      close_flag = (n == msort_pkg::DEPTH) ? 1'($urandom_range(0, 1)) : 1'b1;
      for (int i = 0; i < n; i++)
        send_value(rand_value(), (i == n - 1) ? close_flag : 1'b0);
    end
  endtask

  // Receiver: random stall at the falling edge, take results at the rising edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_out || ($urandom_range(0, 99) < out_idle_pct);
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_value(out_item);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    hold_out = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (200) @(posedge clk);
    hold_out = 1'b0;
  end

  // Run limit
  initial begin
    #2000000;
    $display("merge_sorter_top_test failed");
    $finish;
  end

  // Main sequence
  initial begin
    board        = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    in_idle_pct  = 23;
    out_idle_pct = 84;
    sent         = 0;
    hold_go      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // set of one
    send_value(32'sd5, 1'b1);
    // extremes of the value range
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b1);
    // ties: repeated equal values
    send_value(32'sd7, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'sd7, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'sd7, 1'b1);
    // descending, then already ascending
    send_value(32'sd4, 1'b0);
    send_value(32'sd3, 1'b0);
    send_value(32'sd2, 1'b0);
    send_value(32'sd1, 1'b1);
    send_value(-32'sd2, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(32'sd1, 1'b1);
    // repeated extremes
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh7FFF_FFFF, 1'b0);
    send_value(32'sh8000_0000, 1'b1);

    send_random_sets(160);
    in_idle_pct  = 84;
    out_idle_pct = 23;
    send_random_sets(300);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_go      = 1'b1;
    send_random_sets(420);
    in_valid <= 1'b0;

    // drain, then allow time for any stray result
    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors != 0 || board.loading_q.size() != 0)
      $display("merge_sorter_top_test failed");
    else
      $display("merge_sorter_top_test passed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/msort_pkg.sv
hdl/msort_cell.sv
hdl/merge_sorter_top.sv
bench/merge_sorter_top_test.sv
